[hdl/sma_pkg.sv]
// ---------------------------------------------------------------------------
// sma_pkg
// shared types and constants for the small matrix arithmetic core
// ---------------------------------------------------------------------------
package sma_pkg;

    localparam int FRAC_BITS = 16;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_NEG = 3'd2;
    localparam logic [2:0] OP_SCALE = 3'd3;
    localparam logic [2:0] OP_MUL = 3'd4;
    localparam logic [2:0] OP_UNKNOWN = 3'd7;

    localparam logic [1:0] MODE_LOAD_A = 2'd0;
    localparam logic [1:0] MODE_LOAD_B = 2'd1;
    localparam logic [1:0] MODE_COMPUTE = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [2:0] REG_OPERATION = 3'd0;
    localparam logic [2:0] REG_A_ROWS = 3'd1;
    localparam logic [2:0] REG_A_COLS = 3'd2;
    localparam logic [2:0] REG_B_ROWS = 3'd3;
    localparam logic [2:0] REG_B_COLS = 3'd4;
    localparam logic [2:0] REG_SCALE = 3'd5;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] element_value;
    } in_word_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic        final_flag;
        logic        dimension_error;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic clear_acc;   // start a new element
        logic issue;       // launch a read and multiply step
        logic emit;        // take the accumulated element to the output
        logic last;        // element is the last of the run
        logic error;       // emit the error word
    } dp_cmd_t;

endpackage

[hdl/sma_datapath.sv]
// ---------------------------------------------------------------------------
// sma_datapath
// operand stores, product stage, saturating accumulator and output register
// ---------------------------------------------------------------------------
module sma_datapath
    import sma_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW = 6
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   a_we,
    input  logic                   b_we,
    input  logic [AW-1:0]          wr_addr,
    input  logic [VALUE_WIDTH-1:0] wr_data,
    input  logic [AW-1:0]          a_addr,
    input  logic [AW-1:0]          b_addr,
    input  logic [2:0]             operation,
    input  logic [VALUE_WIDTH-1:0] scale_factor,
    input  dp_cmd_t                cmd,
    input  logic                   out_stall,
    output logic                   out_valid,
    output logic [VALUE_WIDTH-1:0] out_value,
    output logic                   out_final,
    output logic                   out_error
);

    localparam int PW = 2 * VALUE_WIDTH;
    localparam logic signed [VALUE_WIDTH+1:0] VMAX =
        (VALUE_WIDTH+2)'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [VALUE_WIDTH+1:0] VMIN = -VMAX - (VALUE_WIDTH+2)'(1);

    logic [VALUE_WIDTH-1:0] a_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] b_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] a_rd_reg, b_rd_reg;
    logic                   rd_vld_reg, prod_vld_reg;
    logic signed [VALUE_WIDTH-1:0] prod_reg, prod_next;
    logic signed [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic signed [VALUE_WIDTH-1:0] mul_op_b;
    logic signed [PW-1:0]   full_prod;
    logic signed [PW-1:0]   shifted;
    logic signed [VALUE_WIDTH+1:0] sum_wide;

    always_ff @(posedge clk)
    begin
        if (a_we)
            a_mem[wr_addr] <= wr_data;
        if (b_we)
            b_mem[wr_addr] <= wr_data;
        a_rd_reg <= a_mem[a_addr];
        b_rd_reg <= b_mem[b_addr];
    end

    function automatic logic signed [VALUE_WIDTH-1:0] sat_w(
        input logic signed [PW-1:0] v);
        logic signed [VALUE_WIDTH-1:0] r;
        if (v > PW'(VMAX))
            r = VMAX[VALUE_WIDTH-1:0];
        else if (v < PW'(VMIN))
            r = VMIN[VALUE_WIDTH-1:0];
        else
            r = v[VALUE_WIDTH-1:0];
        return r;
    endfunction

    // per-element term: product, sum, difference or negation
    always_comb
    begin
        mul_op_b = (operation == OP_SCALE) ? signed'(scale_factor) : signed'(b_rd_reg);
        full_prod = signed'(a_rd_reg) * mul_op_b;
        shifted = full_prod >>> FRAC_BITS;
        case (operation)
            OP_ADD:  prod_next = sat_w(PW'(signed'(a_rd_reg)) + PW'(signed'(b_rd_reg)));
            OP_SUB:  prod_next = sat_w(PW'(signed'(a_rd_reg)) - PW'(signed'(b_rd_reg)));
            OP_NEG:  prod_next = sat_w(-PW'(signed'(a_rd_reg)));
            default: prod_next = sat_w(shifted);
        endcase
    end

    always_comb
    begin
        sum_wide = (VALUE_WIDTH+2)'(acc_reg) + (VALUE_WIDTH+2)'(prod_reg);
        if (cmd.clear_acc)
            acc_next = '0;
        else if (prod_vld_reg)
        begin
            if (sum_wide > VMAX)
                acc_next = VMAX[VALUE_WIDTH-1:0];
            else if (sum_wide < VMIN)
                acc_next = VMIN[VALUE_WIDTH-1:0];
            else
                acc_next = sum_wide[VALUE_WIDTH-1:0];
        end
        else
            acc_next = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            prod_vld_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.issue;
            prod_vld_reg <= rd_vld_reg;
            if (cmd.emit || cmd.error)
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg <= acc_next;
        if (cmd.error)
        begin
            out_value <= '0;
            out_final <= 1'b1;
            out_error <= 1'b1;
        end
        else if (cmd.emit)
        begin
            out_value <= acc_reg;
            out_final <= cmd.last;
            out_error <= 1'b0;
        end
    end

endmodule

[hdl/sma_controller.sv]
// ---------------------------------------------------------------------------
// sma_controller
// load counters and the compute sequencer over rows, columns and terms
// ---------------------------------------------------------------------------
module sma_controller
    import sma_pkg::*;
#(
    parameter int MAX_DIM = 8,
    parameter int AW = 6,
    parameter int DW = 3
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [1:0]    in_mode,
    output logic          in_stall,
    input  logic [2:0]    operation,
    input  logic [3:0]    a_rows,
    input  logic [3:0]    a_cols,
    input  logic [3:0]    b_rows,
    input  logic [3:0]    b_cols,
    input  logic          out_valid,
    input  logic          out_stall,
    output logic          a_we,
    output logic          b_we,
    output logic [AW-1:0] wr_addr,
    output logic [AW-1:0] a_addr,
    output logic [AW-1:0] b_addr,
    output dp_cmd_t       cmd
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [AW:0] a_cnt_reg, b_cnt_reg;
    logic [DW:0] i_reg, j_reg, k_reg;
    logic [1:0]  drain_reg;
    logic [DW:0] rows, cols, terms;
    logic        ok, take, is_mul;

    function automatic logic dim_ok(input logic [3:0] d);
        return (d != 4'd0) && ({28'd0, d} <= 32'(MAX_DIM));
    endfunction

    assign is_mul = (operation == OP_MUL);
    assign rows = (DW+1)'(a_rows);
    assign cols = is_mul ? (DW+1)'(b_cols) : (DW+1)'(a_cols);
    assign terms = is_mul ? (DW+1)'(a_cols) : (DW+1)'(1);

    always_comb
    begin
        ok = dim_ok(a_rows) && dim_ok(a_cols);
        case (operation)
            OP_ADD, OP_SUB: ok = ok && a_rows == b_rows && a_cols == b_cols;
            OP_NEG, OP_SCALE: ok = ok;
            OP_MUL: ok = ok && dim_ok(b_cols) && a_cols == b_rows;
            default: ok = 1'b0;
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE) || (out_valid && out_stall);
    assign take = in_valid && !in_stall;
    assign a_we = take && in_mode == MODE_LOAD_A && a_cnt_reg < (AW+1)'(DEPTH);
    assign b_we = take && in_mode == MODE_LOAD_B && b_cnt_reg < (AW+1)'(DEPTH);
    assign wr_addr = (in_mode == MODE_LOAD_A) ? a_cnt_reg[AW-1:0] : b_cnt_reg[AW-1:0];

    // element addresses: elementwise use i*cols+j, product uses a[i][k], b[k][j]
    always_comb
    begin
        if (is_mul)
        begin
            a_addr = AW'(i_reg) * AW'(a_cols) + AW'(k_reg);
            b_addr = AW'(k_reg) * AW'(b_cols) + AW'(j_reg);
        end
        else
        begin
            a_addr = AW'(i_reg) * AW'(a_cols) + AW'(j_reg);
            b_addr = a_addr;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.last = (i_reg + 1'b1 == rows) && (j_reg + 1'b1 == cols);
        case (state_reg)
            ST_IDLE:
            begin
                if (take && in_mode == MODE_COMPUTE)
                begin
                    if (ok)
                    begin
                        cmd.clear_acc = 1'b1;
                        state_next = ST_ISSUE;
                    end
                    else
                        cmd.error = 1'b1;
                end
            end
            ST_ISSUE:
            begin
                cmd.issue = 1'b1;
                if (k_reg + 1'b1 == terms)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (drain_reg == 2'd2)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!(out_valid && out_stall))
                begin
                    cmd.emit = 1'b1;
                    cmd.clear_acc = 1'b1;
                    state_next = cmd.last ? ST_IDLE : ST_ISSUE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            a_cnt_reg <= '0;
            b_cnt_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (a_we)
                a_cnt_reg <= a_cnt_reg + 1'b1;
            if (b_we)
                b_cnt_reg <= b_cnt_reg + 1'b1;
            if (take && in_mode == MODE_COMPUTE)
            begin
                a_cnt_reg <= '0;
                b_cnt_reg <= '0;
                i_reg <= '0;
                j_reg <= '0;
                k_reg <= '0;
            end
            if (state_reg == ST_ISSUE && k_reg + 1'b1 != terms)
                k_reg <= k_reg + 1'b1;
            drain_reg <= (state_reg == ST_DRAIN) ? drain_reg + 1'b1 : 2'd0;
            if (cmd.emit)
            begin
                k_reg <= '0;
                if (j_reg + 1'b1 == cols)
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + 1'b1;
                end
                else
                    j_reg <= j_reg + 1'b1;
            end
        end
    end

endmodule

[hdl/small_matrix_arithmetic_core.sv]
// load: a load word is taken and gives no result word
// compute: per element, n multiply-accumulate issues (n = a_cols for the product,
// one otherwise) followed by the read, product, accumulate and emit steps
// a full 8x8 product gives 64 result words; one item at a time
// reset: configuration returns to its defaults, load counters clear, stores unset
// ---------------------------------------------------------------------------
// small_matrix_arithmetic_core
// q16.16 matrix add, subtract, negate, scale and multiply with apb registers
// ---------------------------------------------------------------------------
module small_matrix_arithmetic_core
    import sma_pkg::*;
#(
    parameter int MAX_DIM = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    // item channel
    input  logic       in_valid,
    output logic       in_stall,
    input  in_word_t   in_word,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output out_word_t  out_word,
    // register port
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [4:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);

    localparam int VW = 32;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW = $clog2(DEPTH);
    localparam int DW = $clog2(MAX_DIM);

    // configuration registers
    logic [2:0]  operation_reg;
    logic [3:0]  a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic [31:0] scale_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;

    logic          a_we, b_we;
    logic [AW-1:0] wr_addr, a_addr, b_addr;
    dp_cmd_t       cmd;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operation_reg <= OP_MUL;
            a_rows_reg <= 4'd8;
            a_cols_reg <= 4'd8;
            b_rows_reg <= 4'd8;
            b_cols_reg <= 4'd8;
            scale_reg <= 32'd65536;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_OPERATION: operation_reg <= pwdata[2:0];
                REG_A_ROWS:    a_rows_reg <= pwdata[3:0];
                REG_A_COLS:    a_cols_reg <= pwdata[3:0];
                REG_B_ROWS:    b_rows_reg <= pwdata[3:0];
                REG_B_COLS:    b_cols_reg <= pwdata[3:0];
                REG_SCALE:     scale_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (reg_idx)
            REG_OPERATION: prdata = {29'd0, operation_reg};
            REG_A_ROWS:    prdata = {28'd0, a_rows_reg};
            REG_A_COLS:    prdata = {28'd0, a_cols_reg};
            REG_B_ROWS:    prdata = {28'd0, b_rows_reg};
            REG_B_COLS:    prdata = {28'd0, b_cols_reg};
            REG_SCALE:     prdata = scale_reg;
            default:       prdata = '0;
        endcase
    end

    sma_controller #(.MAX_DIM(MAX_DIM), .AW(AW), .DW(DW)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_mode(in_word.mode), .in_stall(in_stall),
        .operation(operation_reg),
        .a_rows(a_rows_reg), .a_cols(a_cols_reg),
        .b_rows(b_rows_reg), .b_cols(b_cols_reg),
        .out_valid(out_valid), .out_stall(out_stall),
        .a_we(a_we), .b_we(b_we), .wr_addr(wr_addr),
        .a_addr(a_addr), .b_addr(b_addr), .cmd(cmd)
    );

    sma_datapath #(.VALUE_WIDTH(VW), .DEPTH(DEPTH), .AW(AW)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .a_we(a_we), .b_we(b_we), .wr_addr(wr_addr), .wr_data(in_word.element_value),
        .a_addr(a_addr), .b_addr(b_addr),
        .operation(operation_reg), .scale_factor(scale_reg),
        .cmd(cmd), .out_stall(out_stall),
        .out_valid(out_valid), .out_value(out_word.result_value),
        .out_final(out_word.final_flag), .out_error(out_word.dimension_error)
    );

`ifndef SYNTHESIS
    // an error word always closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.dimension_error |-> out_word.final_flag)
        else $error("error word without final flag");
    // no new word is launched over a stalled one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> !cmd.emit && !cmd.error)
        else $error("result overwritten while stalled");
    // store writes never coincide with an issue step of a running sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_we || b_we) |-> !cmd.issue)
        else $error("store written during compute");
`endif

endmodule

[tb/small_matrix_arithmetic_core_tb.sv]
// ---------------------------------------------------------------------------
// small_matrix_arithmetic_core_tb
// self-checking bench: loads matrices, computes under many register settings
// and compares every result word against an in-bench q16.16 predictor
// ---------------------------------------------------------------------------
module small_matrix_arithmetic_core_tb;
    import sma_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam int QUIET_LIMIT = 20000;

    // matrix predictor and queue of expected result words
    class matrix_scoreboard;
        logic [2:0]         op;
        logic [3:0]         ar, ac, br, bc;
        logic signed [31:0] scale;
        logic signed [31:0] a_mem [DEPTH];
        logic signed [31:0] b_mem [DEPTH];
        int                 a_cnt, b_cnt;
        out_word_t          pending [$];
        int                 fails;

        function new();
            op = OP_MUL;
            ar = 4'd8; ac = 4'd8; br = 4'd8; bc = 4'd8;
            scale = 32'sd65536;
            a_cnt = 0; b_cnt = 0; fails = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_OPERATION: op = v[2:0];
                REG_A_ROWS:    ar = v[3:0];
                REG_A_COLS:    ac = v[3:0];
                REG_B_ROWS:    br = v[3:0];
                REG_B_COLS:    bc = v[3:0];
                REG_SCALE:     scale = v;
                default: ;
            endcase
        endfunction

        function logic signed [31:0] clip(longint v);
            if (v > 64'sd2147483647) return 32'sh7fffffff;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        // full product, floor shift back to q16.16, saturate
        function logic signed [31:0] qmul(logic signed [31:0] x, logic signed [31:0] y);
            longint p;
            p = longint'(x) * longint'(y);
            return clip(p >>> FRAC_BITS);
        endfunction

        function bit dim_ok(logic [3:0] d);
            return d >= 1 && d <= 8;
        endfunction

        function void note_word(in_word_t w);
            bit ok;
            int rows, cols;
            longint acc;
            out_word_t r;
            ok = 0;
            if (w.mode == MODE_LOAD_A) begin
                if (a_cnt < DEPTH) begin
                    a_mem[a_cnt] = w.element_value;
                    a_cnt++;
                end
                return;
            end
            if (w.mode == MODE_LOAD_B) begin
                if (b_cnt < DEPTH) begin
                    b_mem[b_cnt] = w.element_value;
                    b_cnt++;
                end
                return;
            end
            if (w.mode != MODE_COMPUTE) return;
            a_cnt = 0;
            b_cnt = 0;
            ok = dim_ok(ar) && dim_ok(ac);
            rows = ar;
            cols = ac;
            if (op == OP_ADD || op == OP_SUB)
                ok = ok && ar == br && ac == bc;
            else if (op == OP_MUL) begin
                ok = ok && dim_ok(bc) && ac == br;
                cols = bc;
            end else if (op > OP_MUL)
                ok = 0;
            if (!ok) begin
                r.result_value = '0;
                r.final_flag = 1'b1;
                r.dimension_error = 1'b1;
                pending.insert(pending.size(), r);
                return;
            end
            for (int i = 0; i < rows; i++)
                for (int j = 0; j < cols; j++) begin
                    int idx;
                    idx = i * cols + j;
                    case (op)
                        OP_ADD:   r.result_value = clip(longint'(a_mem[idx]) + b_mem[idx]);
                        OP_SUB:   r.result_value = clip(longint'(a_mem[idx]) - b_mem[idx]);
                        OP_NEG:   r.result_value = clip(-longint'(a_mem[idx]));
                        OP_SCALE: r.result_value = qmul(a_mem[idx], scale);
                        default:
                        begin
                            acc = 0;
                            for (int k = 0; k < ac; k++)
                                acc = clip(acc + qmul(a_mem[i * ac + k], b_mem[k * bc + j]));
                            r.result_value = acc[31:0];
                        end
                    endcase
                    r.final_flag = (i + 1 == rows) && (j + 1 == cols);
                    r.dimension_error = 1'b0;
                    pending.insert(pending.size(), r);
                end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
            fails++;
        endtask

        task check_result(out_word_t g);
            out_word_t e;
            if (pending.size() == 0) begin
                report("unexpected word", g.result_value, 0);
                return;
            end
            e = pending.pop_front();
            if (g.result_value !== e.result_value)
                report("result_value", g.result_value, e.result_value);
            if (g.final_flag !== e.final_flag)
                report("final_flag", g.final_flag, e.final_flag);
            if (g.dimension_error !== e.dimension_error)
                report("dimension_error", g.dimension_error, e.dimension_error);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_word_t    in_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_word_t   out_word;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    matrix_scoreboard sb = new();

    int send_pct = 0;      // chance in a hundred of a gap before a word
    int stall_pct = 0;     // chance in a hundred of a receiver stall
    int words_sent = 0;    // loads and computes, unused-mode words left out
    int quiet = 0;

    always #5 clk = ~clk;

    small_matrix_arithmetic_core DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // receiver back-pressure
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // result monitor; values read here are the ones held before the edge
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_word);

    // watchdog on cycles with no handshake on either channel and no register access
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("small_matrix_arithmetic_core regression: fail");
            $finish;
        end
    end

    // one register write, setup then access
    task automatic reg_write(logic [2:0] idx, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    // offer one word, optionally after a gap, and hold it until taken
    task automatic send_word(logic [1:0] mode, logic [31:0] v);
        int gap;
        in_word_t w;
        w.mode = mode;
        w.element_value = v;
        gap = ($urandom_range(99) < send_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (in_stall);
        sb.note_word(w);
        if (mode == MODE_COMPUTE || (mode == MODE_LOAD_A && sb.a_cnt <= DEPTH)
            || (mode == MODE_LOAD_B && sb.b_cnt <= DEPTH))
            words_sent++;
    endtask

    // drain all expected words, then let a trailing load settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // q16.16 values: mostly modest, with extremes and full-range noise
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return 32'hffffffff;
            3, 4:    return $urandom();
            default: return $urandom_range(524288) - 262144;
        endcase
    endfunction

    task automatic configure(logic [2:0] op, logic [3:0] ar, logic [3:0] ac,
                             logic [3:0] br, logic [3:0] bc, logic [31:0] sc);
        reg_write(REG_OPERATION, {29'd0, op});
        reg_write(REG_A_ROWS, {28'd0, ar});
        reg_write(REG_A_COLS, {28'd0, ac});
        reg_write(REG_B_ROWS, {28'd0, br});
        reg_write(REG_B_COLS, {28'd0, bc});
        reg_write(REG_SCALE, sc);
    endtask

    // a well-formed run: load both matrices then compute, with some noise
    task automatic run_matrices(int na, int nb, bit noisy);
        for (int i = 0; i < na; i++)
        begin
            if (noisy && $urandom_range(15) == 0)
                send_word(MODE_UNUSED, $urandom());
            send_word(MODE_LOAD_A, pick_value());
        end
        for (int i = 0; i < nb; i++)
            send_word(MODE_LOAD_B, pick_value());
        send_word(MODE_COMPUTE, $urandom());
    endtask

    function automatic logic [3:0] pick_dim();
        case ($urandom_range(19))
            0:       return 4'd0;
            1:       return 4'($urandom_range(9, 15));
            2, 3:    return 4'd8;
            default: return 4'($urandom_range(1, 4));
        endcase
    endfunction

    initial
    begin
        logic [2:0] op;
        logic [3:0] ar, ac, br, bc;
        logic [31:0] sc;
        int na, nb;
        int goal;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every store entry once so no later read hits an unset entry;
        // an extra a load past the end is dropped, mode 3 does nothing
        for (int i = 0; i < DEPTH + 1; i++)
            send_word(MODE_LOAD_A, (i < 4) ? pick_value() : $urandom());
        for (int i = 0; i < DEPTH; i++)
            send_word(MODE_LOAD_B, $urandom_range(131072) - 65536);
        send_word(MODE_UNUSED, 32'hffffffff);
        send_word(MODE_COMPUTE, '0);   // reset setting: 8x8 product
        drain();

        // every operation on 2x2 with extreme values
        for (int o = OP_ADD; o <= OP_MUL; o++)
        begin
            configure(o[2:0], 2, 2, 2, 2, (o == OP_SCALE) ? 32'h80000000 : 32'h7fffffff);
            send_word(MODE_LOAD_A, 32'h80000000);
            send_word(MODE_LOAD_A, 32'h7fffffff);
            send_word(MODE_LOAD_A, 32'h00010000);
            send_word(MODE_LOAD_A, 32'hffffffff);
            send_word(MODE_LOAD_B, 32'h7fffffff);
            send_word(MODE_LOAD_B, 32'h80000000);
            send_word(MODE_LOAD_B, 32'hfffe8000);
            send_word(MODE_LOAD_B, 32'h00000000);
            send_word(MODE_COMPUTE, '0);
            drain();
        end

        // error words: unknown operation, zero and oversize dims, mismatches
        configure(OP_UNKNOWN, 2, 2, 2, 2, 0);
        send_word(MODE_COMPUTE, '0);
        drain();
        configure(OP_NEG, 0, 3, 3, 3, 0);
        send_word(MODE_COMPUTE, '0);
        drain();
        configure(OP_SCALE, 15, 1, 1, 1, 0);
        send_word(MODE_COMPUTE, '0);
        drain();
        configure(OP_ADD, 2, 3, 3, 2, 0);
        send_word(MODE_COMPUTE, '0);
        drain();
        configure(OP_MUL, 2, 3, 2, 3, 0);
        send_word(MODE_COMPUTE, '0);
        drain();

        // three idling regimes over the random part
        for (int ph = 0; ph < 3; ph++)
        begin
            goal = words_sent + 50;
            while (words_sent < goal)
            begin
                if ($urandom_range(3) == 0)
                begin
                    send_pct = 0;
                    stall_pct = 0;
                end
                else
                begin
                    send_pct = (ph == 0) ? 23 : (ph == 1) ? 71 : 0;
                    stall_pct = (ph == 0) ? 71 : (ph == 1) ? 23 : 0;
                end
                op = ($urandom_range(11) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
                ar = pick_dim();
                ac = pick_dim();
                br = ($urandom_range(7) == 0) ? pick_dim() : (op == OP_MUL) ? ac : ar;
                bc = ($urandom_range(7) == 0) ? pick_dim() : (op == OP_MUL) ? pick_dim() : ac;
                case ($urandom_range(5))
                    0:       sc = 32'h7fffffff;
                    1:       sc = 32'h80000000;
                    2:       sc = $urandom();
                    default: sc = $urandom_range(262144) - 131072;
                endcase
                configure(op, ar, ac, br, bc, sc);
                na = (ar >= 1 && ar <= 8 && ac >= 1 && ac <= 8) ? ar * ac : 2;
                nb = (br >= 1 && br <= 8 && bc >= 1 && bc <= 8) ? br * bc : 2;
                if (op == OP_NEG || op == OP_SCALE)
                    nb = $urandom_range(0, 2);
                // occasionally overrun the a store to hit the dropped-load case
                if ($urandom_range(19) == 0)
                    na = DEPTH + 2;
                run_matrices(na, nb, 1'b1);
                drain();
            end
        end

        send_pct = 0;
        stall_pct = 0;
        drain();
        if (sb.fails == 0 && sb.pending.size() == 0)
            $display("small_matrix_arithmetic_core regression: pass");
        else
            $display("small_matrix_arithmetic_core regression: fail");
        $finish;
    end

endmodule
